/* rtl/core/lru_key_value_cache_top_assert.svh */
// Assertion macros used by the cache datapath RTL.
// Both expect signals named clk and arst_n in the enclosing module.
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LKVC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LKVC_ASSERT(lbl, prop, msg)
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/lkvc_pkg.sv */
`timescale 1ns / 1ps
package lkvc_pkg;

	localparam int DATA_W       = 32;
	localparam int KEY_W        = 32;
	localparam int CAP_W        = 5;
	localparam int DEF_ENTRIES  = 16;
	localparam int DEF_KEY_BITS = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// request command codes
	localparam logic [0:0] CMD_GET = 1'b0;
	localparam logic [0:0] CMD_SET = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_COMMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic in_ready;
		logic capture;
		logic lookup;
		logic commit;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_valid;
		logic out_free;
	} ctl_sts_t;

endpackage

/* rtl/core/lkvc_if.sv */
`timescale 1ns / 1ps
interface lkvc_req_if;
	logic                                valid;
	logic                                ready;
	logic [0:0]                          command;
	logic signed [lkvc_pkg::KEY_W-1:0]   key;
	logic signed [lkvc_pkg::DATA_W-1:0]  value;

	modport source (output valid, command, key, value, input ready);
	modport sink   (input valid, command, key, value, output ready);
endinterface

interface lkvc_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                found;
	logic signed [lkvc_pkg::DATA_W-1:0]  read_value;
	logic                                evicted;
	logic signed [lkvc_pkg::KEY_W-1:0]   evicted_key;

	modport source (output valid, found, read_value, evicted, evicted_key, input ready);
	modport sink   (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

interface lkvc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [lkvc_pkg::CAP_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/lru_key_value_cache_top.sv */
`timescale 1ns / 1ps
// Channel  Dir  Transaction
// req      in   command (get/set), key, value
// rsp      out  found, read_value, evicted, evicted_key
// cfg      in   capacity (5 bits), always ready
//
// Each transaction steps through capture, parallel lookup and commit.
// The lookup compares all ENTRIES keys in parallel; commit updates ranks.
// A stalled rsp holds commit; a new req is taken while a result waits.
// Reset clears valid bits, ranks and count at once; no clearing pass.
// Key and value stores have no reset and are read only where valid.
module lru_key_value_cache_top #(
	parameter int ENTRIES  = lkvc_pkg::DEF_ENTRIES,
	parameter int KEY_BITS = lkvc_pkg::DEF_KEY_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	lkvc_req_if.sink    req,
	lkvc_rsp_if.source  rsp,
	lkvc_cfg_if.sink    cfg
);

	// command and status between the sequencer and the entry datapath
	lkvc_pkg::ctl_cmd_t ctl_cmd;
	lkvc_pkg::ctl_sts_t ctl_sts;

	// sequencer: idle -> lookup -> commit, commit waits on a free result slot
	lkvc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (ctl_sts),
		.cmd    (ctl_cmd)
	);

	// entry array, LRU ranks, capacity register and result register
	lkvc_datapath #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (ctl_cmd),
		.sts    (ctl_sts)
	);

endmodule

/* rtl/core/lkvc_ctrl.sv */
`timescale 1ns / 1ps
module lkvc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  lkvc_pkg::ctl_sts_t sts,
	output lkvc_pkg::ctl_cmd_t cmd
);

	lkvc_pkg::state_t state_q;
	lkvc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lkvc_pkg::ST_IDLE: begin
				if (sts.in_valid) state_d = lkvc_pkg::ST_LOOKUP;
			end
			lkvc_pkg::ST_LOOKUP: begin
				state_d = lkvc_pkg::ST_COMMIT;
			end
			lkvc_pkg::ST_COMMIT: begin
				// hold until the result register can take the answer
				if (sts.out_free) state_d = lkvc_pkg::ST_IDLE;
			end
			default: begin
				state_d = lkvc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			lkvc_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.capture  = sts.in_valid;
			end
			lkvc_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			lkvc_pkg::ST_COMMIT: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/core/lkvc_datapath.sv */
`timescale 1ns / 1ps
`include "lru_key_value_cache_top_assert.svh"
module lkvc_datapath #(
	parameter int ENTRIES  = lkvc_pkg::DEF_ENTRIES,
	parameter int KEY_BITS = lkvc_pkg::DEF_KEY_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	lkvc_req_if.sink           req,
	lkvc_rsp_if.source         rsp,
	lkvc_cfg_if.sink           cfg,
	input  lkvc_pkg::ctl_cmd_t cmd,
	output lkvc_pkg::ctl_sts_t sts
);

	// stored key width: only the low KEY_BITS of the key port take part
	localparam int SW = (KEY_BITS < lkvc_pkg::KEY_W) ? KEY_BITS : lkvc_pkg::KEY_W;
	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int XW = lkvc_pkg::CAP_W + 3;
	localparam int DW = lkvc_pkg::DATA_W;

	// configuration
	logic [lkvc_pkg::CAP_W-1:0] capacity_q;
	logic [XW-1:0]              cap_x;
	logic [XW-1:0]              eff_cap;

	// entry state
	logic [ENTRIES-1:0] valid_q;
	logic [RW-1:0]      rank_q [ENTRIES];
	logic [CW-1:0]      live_q;
	logic [SW-1:0]      key_mem [ENTRIES];
	logic [DW-1:0]      val_mem [ENTRIES];

	// request stage
	logic [0:0]    cmd_s1;
	logic [SW-1:0] key_s1;
	logic [DW-1:0] value_s1;

	// lookup results
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] lru_vec;
	logic [ENTRIES-1:0] vic_vec;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] slot_vec;
	logic               found;
	logic               is_set;
	logic               evict;
	logic               insert;
	logic [RW-1:0]      hit_rank;
	logic [RW-1:0]      lru_rank;
	logic [DW-1:0]      hit_value;
	logic [SW-1:0]      vic_key;

	logic [ENTRIES-1:0] hit_s2;
	logic [ENTRIES-1:0] slot_s2;
	logic [ENTRIES-1:0] vic_s2;
	logic               found_s2;
	logic               set_s2;
	logic               ins_s2;
	logic               evict_s2;
	logic [RW-1:0]      hit_rank_s2;
	logic [DW-1:0]      rd_s2;
	logic [SW-1:0]      evk_s2;

	// result register
	logic          rsp_valid_q;
	logic          found_q;
	logic [DW-1:0] read_value_q;
	logic          evicted_q;
	logic [SW-1:0] evicted_key_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg.valid) begin
			capacity_q <= cfg.data;
		end
	end

	// zero acts as one, anything above the entry count saturates
	always_comb begin
		cap_x = XW'(capacity_q);
		if (cap_x == '0) begin
			eff_cap = XW'(1);
		end else if (cap_x > XW'(ENTRIES)) begin
			eff_cap = XW'(ENTRIES);
		end else begin
			eff_cap = cap_x;
		end
	end

	assign req.ready    = cmd.in_ready;
	assign sts.in_valid = req.valid;
	assign sts.out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_s1   <= req.command;
			key_s1   <= req.key[SW-1:0];
			value_s1 <= req.value;
		end
	end

	// parallel tag compare; the LRU entry is the valid one ranked live-1
	assign lru_rank = RW'(live_q - CW'(1));

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]   = valid_q[i] && (key_mem[i] == key_s1);
			lru_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
		end
	end

	assign hit_vec  = match & (~match + ENTRIES'(1));
	assign found    = |match;
	assign is_set   = (cmd_s1 == lkvc_pkg::CMD_SET);
	assign evict    = is_set && !found && (XW'(live_q) >= eff_cap) && (live_q != '0);
	assign vic_vec  = evict ? lru_vec : '0;
	assign free_vec = ~(valid_q & ~vic_vec);
	assign slot_vec = free_vec & (~free_vec + ENTRIES'(1));
	assign insert   = is_set && !found && (|free_vec);

	always_comb begin
		hit_rank  = '0;
		hit_value = '0;
		vic_key   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_rank  = hit_rank  | (hit_vec[i] ? rank_q[i]  : '0);
			hit_value = hit_value | (hit_vec[i] ? val_mem[i] : '0);
			vic_key   = vic_key   | (vic_vec[i] ? key_mem[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_s2      <= hit_vec;
			slot_s2     <= slot_vec;
			vic_s2      <= vic_vec;
			found_s2    <= found;
			set_s2      <= is_set;
			ins_s2      <= insert;
			evict_s2    <= evict;
			hit_rank_s2 <= hit_rank;
			rd_s2       <= (!is_set && found) ? hit_value : '0;
			evk_s2      <= evict ? vic_key : '0;
		end
	end

	// recency and occupancy update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (found_s2) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (hit_s2[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank_s2)) begin
						rank_q[i] <= rank_q[i] + RW'(1);
					end
				end
			end else if (ins_s2) begin
				live_q <= live_q + CW'(1) - (evict_s2 ? CW'(1) : CW'(0));
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_s2[i]) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (vic_s2[i]) begin
						valid_q[i] <= 1'b0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + RW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (found_s2 && set_s2 && hit_s2[i]) begin
					val_mem[i] <= value_s1;
				end else if (ins_s2 && slot_s2[i]) begin
					key_mem[i] <= key_s1;
					val_mem[i] <= value_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found_q       <= found_s2;
			read_value_q  <= rd_s2;
			evicted_q     <= evict_s2;
			evicted_key_q <= evk_s2;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = found_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.evicted     = evicted_q;
	assign rsp.evicted_key = lkvc_pkg::KEY_W'(evicted_key_q);

	`LKVC_ASSERT(a_live_matches_valid, live_q == CW'($countones(valid_q)), "live count disagrees with valid bits")
	`LKVC_ASSERT_NEXT(a_hit_onehot, cmd.lookup, $onehot0(hit_s2), "more than one entry hit")
	`LKVC_ASSERT_NEXT(a_hit_or_insert, cmd.lookup, !(found_s2 && ins_s2), "hit and insert together")
	`LKVC_ASSERT(a_rsp_from_commit, $rose(rsp_valid_q) |-> $past(cmd.commit), "result without commit")

endmodule
